// ----- hw/rtl/apjs_pkg.sv -----
// package for the aging priority job scheduler
// shared constants, entry and control types; no dependencies
`default_nettype none
package apjs_pkg;

    localparam int NUM_LEVELS  = 3;
    localparam int LEVEL_DEPTH = 64;
    localparam int LEVEL_AW    = 6;
    localparam int LEVEL_CW    = 7;
    localparam int READY_DEPTH = 16;
    localparam int READY_IW    = 4;
    localparam int READY_CW    = 5;
    localparam int PRIO_W      = 8;
    localparam int PRIO_MAX    = 255;
    localparam int ID_W        = 16;
    localparam int SIZE_W      = 3;
    localparam int AGE_W       = 4;

    localparam logic CFG_READY_CAPACITY = 1'b0;
    localparam logic CFG_AGING_PERIOD   = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [PRIO_W-1:0] prio;
        logic [AGE_W-1:0]  age;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } fifo_word_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_UPDATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [READY_IW-1:0] load_pos;
        entry_t              load_entry;
        logic [READY_IW-1:0] best;
        logic                finish;
        logic [AGE_W-1:0]    period_m1;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REFILL_RD,
        S_REFILL_WR,
        S_SCAN,
        S_SERVE,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/apjs_job_if.sv -----
// handshake channel for arriving jobs and for per-tick results
// depends on apjs_pkg for field widths
`default_nettype none
interface apjs_job_if;
    logic                          valid;
    logic                          ready;
    logic                          job_valid;
    logic [apjs_pkg::ID_W-1:0]     job_id;
    logic [1:0]                    job_priority;
    logic [apjs_pkg::SIZE_W-1:0]   job_len;

    modport source (output valid, job_valid, job_id, job_priority, job_len, input ready);
    modport sink   (input valid, job_valid, job_id, job_priority, job_len, output ready);
endinterface

interface apjs_res_if;
    logic                            valid;
    logic                            ready;
    logic                            ran_valid;
    logic [apjs_pkg::ID_W-1:0]       ran_job;
    logic                            job_finished;
    logic                            arrival_dropped;
    logic [apjs_pkg::READY_CW-1:0]   ready_count;
    logic [7:0]                      waiting_count;

    modport source (output valid, ran_valid, ran_job, job_finished, arrival_dropped,
                    ready_count, waiting_count, input ready);
    modport sink   (input valid, ran_valid, ran_job, job_finished, arrival_dropped,
                    ready_count, waiting_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/apjs_level_fifo.sv -----
// three level FIFOs sharing one memory, with head and count per level
// depends on apjs_pkg
`default_nettype none
module apjs_level_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_en,
    input  wire logic [1:0]            push_lvl,
    input  wire apjs_pkg::fifo_word_t  push_data,
    input  wire logic                  pop_en,
    input  wire logic [1:0]            pop_lvl,
    output apjs_pkg::fifo_word_t       rd_data,
    output logic [apjs_pkg::NUM_LEVELS-1:0][apjs_pkg::LEVEL_CW-1:0] count
);
    localparam int MEM_DEPTH = apjs_pkg::NUM_LEVELS * apjs_pkg::LEVEL_DEPTH;

    apjs_pkg::fifo_word_t mem [MEM_DEPTH];
    logic [apjs_pkg::NUM_LEVELS-1:0][apjs_pkg::LEVEL_AW-1:0] head_reg;
    logic [apjs_pkg::NUM_LEVELS-1:0][apjs_pkg::LEVEL_CW-1:0] count_reg;
    logic [apjs_pkg::LEVEL_AW-1:0] tail;

    assign count = count_reg;
    assign tail  = head_reg[push_lvl] + count_reg[push_lvl][apjs_pkg::LEVEL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[{push_lvl, tail}] <= push_data;
        end
        if (pop_en)
        begin
            rd_data <= mem[{pop_lvl, head_reg[pop_lvl]}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            // push and pop never fall in the same cycle
            if (push_en)
            begin
                count_reg[push_lvl] <= count_reg[push_lvl] + 1'b1;
            end
            else if (pop_en)
            begin
                head_reg[pop_lvl]  <= head_reg[pop_lvl] + 1'b1;
                count_reg[pop_lvl] <= count_reg[pop_lvl] - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/apjs_cell.sv -----
// one ready-queue cell: holds one job, shifts from its upper neighbor on removal
// depends on apjs_pkg
`default_nettype none
module apjs_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [apjs_pkg::READY_IW-1:0] pos,
    input  wire apjs_pkg::cell_ctrl_t          ctrl,
    input  wire apjs_pkg::entry_t              nbr_entry,
    input  wire logic                          nbr_valid,
    output apjs_pkg::entry_t                   entry,
    output logic                               valid
);
    apjs_pkg::entry_t entry_reg, entry_next, src;
    logic valid_reg, valid_next, src_valid, shift;

    assign entry = entry_reg;
    assign valid = valid_reg;

    always_comb
    begin
        shift      = ctrl.finish && (pos >= ctrl.best);
        src        = shift ? nbr_entry : entry_reg;
        src_valid  = shift ? nbr_valid : valid_reg;
        entry_next = entry_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            apjs_pkg::CELL_LOAD:
            begin
                if (pos == ctrl.load_pos)
                begin
                    entry_next = ctrl.load_entry;
                    valid_next = 1'b1;
                end
            end
            apjs_pkg::CELL_UPDATE:
            begin
                entry_next = src;
                valid_next = src_valid;
                if (!ctrl.finish && pos == ctrl.best)
                begin
                    entry_next.size = src.size - 1'b1;
                end
                // aging of every job still ready
                if (src.age >= ctrl.period_m1)
                begin
                    entry_next.age = '0;
                    if (src.prio != apjs_pkg::PRIO_W'(apjs_pkg::PRIO_MAX))
                    begin
                        entry_next.prio = src.prio + 1'b1;
                    end
                end
                else
                begin
                    entry_next.age = src.age + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/aging_priority_job_scheduler_top.sv -----
// top level of the aging priority job scheduler: tick sequencer and cell chain
// depends on apjs_pkg, apjs_job_if, apjs_res_if, apjs_level_fifo, apjs_cell
`default_nettype none
// One accepted item is one scheduler tick and yields one result item. A tick
// first moves jobs from the level FIFOs into the ready queue (each move is a
// read of the shared FIFO memory, then a load into a cell); then the priority
// scan walks the ready jobs, one cell per cycle, and the best one is served. A
// tick that finds the ready queue empty skips the scan and the serve. At most
// 16 jobs are ready. The result waits in an output register, so the next item
// is taken while it is still pending; a tick stalls at its end only while that
// register still holds an unaccepted result.
module aging_priority_job_scheduler_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    apjs_job_if.sink        job,
    apjs_res_if.source      res,
    input  wire logic       cfg_we,
    input  wire logic       cfg_addr,
    input  wire logic [4:0] cfg_wdata
);
    localparam int RD = apjs_pkg::READY_DEPTH;

    apjs_pkg::state_t state_reg, state_next;
    logic [4:0] cap_reg;
    logic [apjs_pkg::AGE_W-1:0] period_reg;
    logic [apjs_pkg::READY_CW-1:0] ready_n_reg, ready_n_next, cap;
    logic [apjs_pkg::READY_CW-1:0] idx_reg, idx_next;
    logic [apjs_pkg::READY_IW-1:0] best_reg, best_next;
    logic [1:0] pop_lvl_reg, pop_lvl_next;
    logic dropped_reg, dropped_next;
    logic ran_reg, ran_next, fin_reg, fin_next;
    logic [apjs_pkg::ID_W-1:0] ran_id_reg, ran_id_next;

    logic out_valid_reg, out_valid_next, out_load;
    logic out_ran_reg, out_fin_reg, out_drop_reg;
    logic [apjs_pkg::ID_W-1:0] out_id_reg;
    logic [apjs_pkg::READY_CW-1:0] out_rc_reg;
    logic [7:0] out_wc_reg, waiting;

    logic push_en, pop_en;
    logic [1:0] push_lvl, pop_lvl;
    apjs_pkg::fifo_word_t push_data, rd_data;
    logic [apjs_pkg::NUM_LEVELS-1:0][apjs_pkg::LEVEL_CW-1:0] fcount;

    apjs_pkg::cell_ctrl_t ctrl;
    apjs_pkg::entry_t cell_entry [RD+1];
    logic [RD:0] cell_valid;
    apjs_pkg::entry_t best_entry;
    logic accept;

    apjs_level_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (push_en),
        .push_lvl  (push_lvl),
        .push_data (push_data),
        .pop_en    (pop_en),
        .pop_lvl   (pop_lvl),
        .rd_data   (rd_data),
        .count     (fcount)
    );

    assign cell_entry[RD] = '0;
    assign cell_valid[RD] = 1'b0;

    for (genvar g = 0; g < RD; g++)
    begin : g_cell
        apjs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .pos       (apjs_pkg::READY_IW'(g)),
            .ctrl      (ctrl),
            .nbr_entry (cell_entry[g+1]),
            .nbr_valid (cell_valid[g+1]),
            .entry     (cell_entry[g]),
            .valid     (cell_valid[g])
        );
    end

    assign cap     = (cap_reg > 5'(RD)) ? 5'(RD) : cap_reg;
    assign waiting = 8'(fcount[0]) + 8'(fcount[1]) + 8'(fcount[2]);
    assign accept  = job.valid && job.ready;
    assign push_data.id   = job.job_id;
    assign push_data.size = job.job_len;
    assign push_lvl       = job.job_priority - 1'b1;
    assign best_entry     = cell_entry[best_reg];

    always_comb
    begin
        state_next     = state_reg;
        ready_n_next   = ready_n_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        pop_lvl_next   = pop_lvl_reg;
        dropped_next   = dropped_reg;
        ran_next       = ran_reg;
        fin_next       = fin_reg;
        ran_id_next    = ran_id_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_load       = 1'b0;
        job.ready      = 1'b0;
        push_en        = 1'b0;
        pop_en         = 1'b0;
        pop_lvl        = 2'd0;
        ctrl           = '0;
        ctrl.op        = apjs_pkg::CELL_HOLD;
        ctrl.best      = best_reg;
        ctrl.period_m1 = (period_reg == '0) ? '0 : period_reg - 1'b1;
        ctrl.load_pos  = ready_n_reg[apjs_pkg::READY_IW-1:0];
        ctrl.load_entry.id   = rd_data.id;
        ctrl.load_entry.size = rd_data.size;
        ctrl.load_entry.prio = apjs_pkg::PRIO_W'(pop_lvl_reg) + 1'b1;
        ctrl.load_entry.age  = '0;
        unique case (state_reg)
            apjs_pkg::S_IDLE:
            begin
                job.ready = 1'b1;
                if (accept)
                begin
                    dropped_next = 1'b0;
                    ran_next     = 1'b0;
                    fin_next     = 1'b0;
                    ran_id_next  = '0;
                    if (job.job_valid)
                    begin
                        if (job.job_priority == 2'd0 ||
                            fcount[push_lvl] >= apjs_pkg::LEVEL_CW'(apjs_pkg::LEVEL_DEPTH))
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            push_en = 1'b1;
                        end
                    end
                    state_next = apjs_pkg::S_REFILL_RD;
                end
            end
            apjs_pkg::S_REFILL_RD:
            begin
                if (ready_n_reg < cap &&
                    (fcount[2] != '0 || fcount[1] != '0 || fcount[0] != '0))
                begin
                    // highest nonempty level goes first
                    if (fcount[2] != '0)
                    begin
                        pop_lvl = 2'd2;
                    end
                    else if (fcount[1] != '0)
                    begin
                        pop_lvl = 2'd1;
                    end
                    else
                    begin
                        pop_lvl = 2'd0;
                    end
                    pop_en       = 1'b1;
                    pop_lvl_next = pop_lvl;
                    state_next   = apjs_pkg::S_REFILL_WR;
                end
                else if (ready_n_reg == '0)
                begin
                    state_next = apjs_pkg::S_DONE;
                end
                else
                begin
                    best_next  = '0;
                    idx_next   = 5'd1;
                    state_next = apjs_pkg::S_SCAN;
                end
            end
            apjs_pkg::S_REFILL_WR:
            begin
                ctrl.op      = apjs_pkg::CELL_LOAD;
                ready_n_next = ready_n_reg + 1'b1;
                state_next   = apjs_pkg::S_REFILL_RD;
            end
            apjs_pkg::S_SCAN:
            begin
                if (idx_reg == ready_n_reg)
                begin
                    state_next = apjs_pkg::S_SERVE;
                end
                else
                begin
                    if (cell_entry[idx_reg[apjs_pkg::READY_IW-1:0]].prio > best_entry.prio)
                    begin
                        best_next = idx_reg[apjs_pkg::READY_IW-1:0];
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            apjs_pkg::S_SERVE:
            begin
                ctrl.op      = apjs_pkg::CELL_UPDATE;
                ctrl.finish  = (best_entry.size <= 3'd1);
                ran_next     = 1'b1;
                ran_id_next  = best_entry.id;
                fin_next     = ctrl.finish;
                ready_n_next = ready_n_reg - 5'(ctrl.finish);
                state_next   = apjs_pkg::S_DONE;
            end
            apjs_pkg::S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = apjs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = apjs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apjs_pkg::S_IDLE;
            ready_n_reg   <= '0;
            out_valid_reg <= 1'b0;
            cap_reg       <= 5'd16;
            period_reg    <= 4'd10;
        end
        else
        begin
            state_reg     <= state_next;
            ready_n_reg   <= ready_n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    apjs_pkg::CFG_READY_CAPACITY: cap_reg    <= cfg_wdata;
                    apjs_pkg::CFG_AGING_PERIOD:   period_reg <= cfg_wdata[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        best_reg    <= best_next;
        pop_lvl_reg <= pop_lvl_next;
        dropped_reg <= dropped_next;
        ran_reg     <= ran_next;
        fin_reg     <= fin_next;
        ran_id_reg  <= ran_id_next;
        if (out_load)
        begin
            out_ran_reg  <= ran_reg;
            out_id_reg   <= ran_id_reg;
            out_fin_reg  <= fin_reg;
            out_drop_reg <= dropped_reg;
            out_rc_reg   <= ready_n_reg;
            out_wc_reg   <= waiting;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.ran_valid       = out_ran_reg;
    assign res.ran_job         = out_id_reg;
    assign res.job_finished    = out_fin_reg;
    assign res.arrival_dropped = out_drop_reg;
    assign res.ready_count     = out_rc_reg;
    assign res.waiting_count   = out_wc_reg;
endmodule
`default_nettype wire
